[rtl/der_ecdsa_signature_to_raw_macros.svh]
// Assertion macros for the RTL files; dersig_queue uses them.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef DER_ECDSA_SIGNATURE_TO_RAW_MACROS_SVH
`define DER_ECDSA_SIGNATURE_TO_RAW_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DERSIG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dersig: assertion failed");

// Condition that must hold in the cycle after the trigger.
`define DERSIG_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("dersig: assertion failed one cycle after trigger");

`endif

[rtl/dersig_pkg.sv]
`timescale 1ns / 1ps

package dersig_pkg;

  // Layout of the raw signature.
  localparam int HalfBytes     = 32;
  localparam int MaxFieldBytes = 33;
  localparam int OutWords      = 8;
  localparam int WordBytes     = 8;

  // Smallest total length a valid response can have.
  localparam logic [7:0] MinTotal = 8'd6;

  // One byte write from the parser into the current slot.
  typedef struct packed {
    logic       en;
    logic [5:0] idx;
    logic [7:0] data;
  } byte_wr_t;

  // Close the current slot at the end of a response.
  typedef struct packed {
    logic en;
    logic err;
  } push_t;

  // Word read and release request from the output side.
  typedef struct packed {
    logic [2:0] widx;
    logic       pop;
  } rd_req_t;

  // What the oldest finished slot offers to the output side.
  typedef struct packed {
    logic        valid;
    logic        err;
    logic [63:0] word;
  } head_t;

endpackage

[rtl/dersig_in_if.sv]
`timescale 1ns / 1ps

// Byte stream of a DER signature response.
interface dersig_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_response;

  modport source (output valid, output data_byte, output end_of_response, input ready);
  modport sink (input valid, input data_byte, input end_of_response, output ready);
endinterface

[rtl/dersig_out_if.sv]
`timescale 1ns / 1ps

// Raw signature words or a single error result.
interface dersig_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sig_word;
  logic [2:0]  word_index;
  logic        status;
  logic        final_word;

  modport source (output valid, output sig_word, output word_index, output status,
                  output final_word, input ready);
  modport sink (input valid, input sig_word, input word_index, input status,
                input final_word, output ready);
endinterface

[rtl/dersig_front.sv]
`timescale 1ns / 1ps

// DER parser: takes one byte per transaction and writes r and s bytes into the open slot.
module dersig_front (
  input  logic                clk,
  input  logic                rst_n,
  dersig_in_if.sink           in_bus,
  input  logic                q_free,
  output dersig_pkg::byte_wr_t wr,
  output dersig_pkg::push_t    push
);

  // Parse phases.
  localparam logic [3:0] PH_SEQ_TAG = 4'd0;
  localparam logic [3:0] PH_SEQ_LEN = 4'd1;
  localparam logic [3:0] PH_R_TAG   = 4'd2;
  localparam logic [3:0] PH_R_LEN   = 4'd3;
  localparam logic [3:0] PH_R_DATA  = 4'd4;
  localparam logic [3:0] PH_S_TAG   = 4'd5;
  localparam logic [3:0] PH_S_LEN   = 4'd6;
  localparam logic [3:0] PH_S_DATA  = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  // Field handling modes.
  localparam logic [1:0] SOS_COPY  = 2'd0;
  localparam logic [1:0] SOS_STRIP = 2'd1;
  localparam logic [1:0] SOS_SKIP  = 2'd2;

  localparam logic [7:0] SEQ_TAG  = 8'h30;
  localparam logic [7:0] INT_TAG  = 8'h02;
  localparam logic [7:0] ZERO_B   = 8'h00;
  localparam logic [7:0] HALF_LEN = 8'(dersig_pkg::HalfBytes);
  localparam logic [7:0] MAX_LEN  = 8'(dersig_pkg::MaxFieldBytes);
  localparam logic [7:0] POS_MAX  = 8'hff;

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] tot_r, tot_nxt;
  logic [7:0] flen_r, flen_nxt;
  logic [3:0] ph_r, ph_nxt;
  logic [5:0] fcnt_r, fcnt_nxt;
  logic [1:0] sos_r, sos_nxt;
  logic       err_r, err_nxt;

  logic       acc;
  logic [7:0] b;
  logic [1:0] sos_first, sos_eff;
  logic [7:0] base, off, dst, i_inc;
  logic       keep;
  logic [8:0] received;
  logic       ok;

  assign in_bus.ready = q_free;
  assign acc          = in_bus.valid && in_bus.ready;
  assign b            = in_bus.data_byte;

  // Placement of a data byte inside its half.
  always_comb begin
    if ((flen_r == MAX_LEN) && (b == ZERO_B) && ((MAX_LEN - 8'd1) <= HALF_LEN)) begin
      sos_first = SOS_STRIP;
    end else if (flen_r > HALF_LEN) begin
      sos_first = SOS_SKIP;
    end else begin
      sos_first = SOS_COPY;
    end
    sos_eff = (fcnt_r == 6'd0) ? sos_first : sos_r;
    base    = (ph_r == PH_S_DATA) ? HALF_LEN : 8'd0;
    off     = HALF_LEN + {2'b00, fcnt_r};
    dst     = base + off - flen_r;
    keep    = (sos_eff != SOS_SKIP) && !((sos_eff == SOS_STRIP) && (fcnt_r == 6'd0)) &&
              (off >= flen_r) && (dst[7:6] == 2'b00);
    i_inc   = {2'b00, fcnt_r} + 8'd1;
  end

  // Next parser state, byte writes and end of response.
  always_comb begin
    pos_nxt  = pos_r;
    tot_nxt  = tot_r;
    flen_nxt = flen_r;
    ph_nxt   = ph_r;
    fcnt_nxt = fcnt_r;
    sos_nxt  = sos_r;
    err_nxt  = err_r;
    wr       = '0;
    push     = '0;
    received = {1'b0, pos_r} + 9'd1;
    ok       = 1'b0;
    if (acc) begin
      if (pos_r == 8'd0) begin
        if (b != SEQ_TAG) begin
          err_nxt = 1'b1;
        end
        ph_nxt = PH_SEQ_LEN;
      end else if (pos_r == 8'd1) begin
        tot_nxt = b + 8'd2;
        ph_nxt  = PH_R_TAG;
      end else if (pos_r < tot_r) begin
        case (ph_r)
          PH_R_TAG, PH_S_TAG: begin
            if (b != INT_TAG) begin
              err_nxt = 1'b1;
              ph_nxt  = PH_DONE;
            end else begin
              ph_nxt = (ph_r == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
            end
          end
          PH_R_LEN, PH_S_LEN: begin
            flen_nxt = b;
            fcnt_nxt = 6'd0;
            sos_nxt  = SOS_COPY;
            if (b > MAX_LEN) begin
              err_nxt = 1'b1;
              ph_nxt  = PH_DONE;
            end else if (b == 8'd0) begin
              ph_nxt = (ph_r == PH_R_LEN) ? PH_S_TAG : PH_DONE;
            end else begin
              ph_nxt = (ph_r == PH_R_LEN) ? PH_R_DATA : PH_S_DATA;
            end
          end
          PH_R_DATA, PH_S_DATA: begin
            sos_nxt = sos_eff;
            if (keep) begin
              wr.en   = 1'b1;
              wr.idx  = dst[5:0];
              wr.data = b;
            end
            fcnt_nxt = i_inc[5:0];
            if (i_inc >= flen_r) begin
              ph_nxt = (ph_r == PH_R_DATA) ? PH_S_TAG : PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
      pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 8'd1;

      // Close the response and start the next one from a clean state.
      if (in_bus.end_of_response) begin
        ok = !err_nxt && (received >= 9'd2) && ({1'b0, tot_nxt} <= received) &&
             (tot_nxt >= dersig_pkg::MinTotal) && (ph_nxt == PH_DONE);
        push.en  = 1'b1;
        push.err = !ok;
        pos_nxt  = 8'd0;
        tot_nxt  = 8'd0;
        flen_nxt = 8'd0;
        ph_nxt   = PH_SEQ_TAG;
        fcnt_nxt = 6'd0;
        sos_nxt  = SOS_COPY;
        err_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      tot_r  <= 8'd0;
      flen_r <= 8'd0;
      ph_r   <= PH_SEQ_TAG;
      fcnt_r <= 6'd0;
      sos_r  <= SOS_COPY;
      err_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      tot_r  <= tot_nxt;
      flen_r <= flen_nxt;
      ph_r   <= ph_nxt;
      fcnt_r <= fcnt_nxt;
      sos_r  <= sos_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

[rtl/dersig_queue.sv]
`timescale 1ns / 1ps
`include "der_ecdsa_signature_to_raw_macros.svh"

// Two response slots between parser and output: one fills while the other drains.
module dersig_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dersig_pkg::byte_wr_t wr,
  input  dersig_pkg::push_t    push,
  input  dersig_pkg::rd_req_t  rd,
  output logic                 q_free,
  output dersig_pkg::head_t    head
);

  localparam int LaneMax = dersig_pkg::WordBytes - 1;

  logic [63:0] sig_r [2][dersig_pkg::OutWords];
  logic [63:0] vld_r [2];
  logic [1:0]  full_r;
  logic [1:0]  err_r;
  logic        wsel_r;
  logic        rsel_r;
  logic [2:0]  wr_lane;
  logic [63:0] raw_word;

  assign q_free  = !full_r[wsel_r];
  assign wr_lane = 3'(LaneMax) - wr.idx[2:0];

  // Head slot: bytes never written in this response read as zero.
  assign raw_word = sig_r[rsel_r][rd.widx];
  always_comb begin
    head.valid = full_r[rsel_r];
    head.err   = err_r[rsel_r];
    head.word  = '0;
    for (int j = 0; j < dersig_pkg::WordBytes; j++) begin
      if (vld_r[rsel_r][{rd.widx, 3'(j)}]) begin
        head.word[{3'(LaneMax - j), 3'b000} +: 8] = raw_word[{3'(LaneMax - j), 3'b000} +: 8];
      end
    end
  end

  // Byte storage, big-endian within each word.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      sig_r[wsel_r][wr.idx[5:3]][{wr_lane, 3'b000} +: 8] <= wr.data;
    end
  end

  // Slot ownership and per-byte valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= '0;
      vld_r[1] <= '0;
      full_r   <= 2'b00;
      err_r    <= 2'b00;
      wsel_r   <= 1'b0;
      rsel_r   <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wsel_r][wr.idx] <= 1'b1;
      end
      if (push.en) begin
        full_r[wsel_r] <= 1'b1;
        err_r[wsel_r]  <= push.err;
        wsel_r         <= !wsel_r;
      end
      if (rd.pop) begin
        full_r[rsel_r] <= 1'b0;
        vld_r[rsel_r]  <= '0;
        rsel_r         <= !rsel_r;
      end
    end
  end

  `DERSIG_ASSERT(a_push_into_free, push.en |-> !full_r[wsel_r])
  `DERSIG_ASSERT(a_pop_from_full, rd.pop |-> full_r[rsel_r])
  `DERSIG_ASSERT(a_ptr_consistent, (wsel_r == rsel_r) |-> (full_r[0] == full_r[1]))
  `DERSIG_ASSERT_NEXT(a_pop_clears_slot, rd.pop, vld_r[$past(rsel_r)] == '0)

endmodule

[rtl/dersig_back.sv]
`timescale 1ns / 1ps

// Output side: walks the head slot one word per transaction through an output register.
module dersig_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dersig_pkg::head_t    head,
  output dersig_pkg::rd_req_t  rd,
  dersig_out_if.source         out_bus
);

  localparam logic [2:0] LAST_WORD = 3'(dersig_pkg::OutWords - 1);

  logic        at_last;
  logic [2:0]  widx_cnt_r;
  logic        out_valid_r;
  logic [63:0] out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_st_r;
  logic        out_fin_r;
  logic        adv;

  assign at_last = (widx_cnt_r == LAST_WORD);

  // Load a new result when the head slot offers one and the register is empty or being taken.
  assign adv     = head.valid && (!out_valid_r || out_bus.ready);
  assign rd.widx = widx_cnt_r;
  assign rd.pop  = adv && (head.err || at_last);

  assign out_bus.valid      = out_valid_r;
  assign out_bus.sig_word   = out_word_r;
  assign out_bus.word_index = out_idx_r;
  assign out_bus.status     = out_st_r;
  assign out_bus.final_word = out_fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_cnt_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      widx_cnt_r  <= rd.pop ? 3'd0 : widx_cnt_r + 3'd1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= head.err ? 64'd0 : head.word;
      out_idx_r  <= head.err ? 3'd0 : widx_cnt_r;
      out_st_r   <= head.err;
      out_fin_r  <= head.err || at_last;
    end
  end

endmodule

[rtl/der_ecdsa_signature_to_raw.sv]
`timescale 1ns / 1ps

// Channel   | Dir | Payload                                        | Handshake
// in_bus    | in  | data_byte[7:0], end_of_response                | valid/ready
// out_bus   | out | sig_word[63:0], word_index[2:0], status, final | valid/ready
//
// Input takes one byte per cycle while a response slot is free; two slots hold responses.
// A good response yields eight words from its slot, one per cycle while out_bus is ready.
// A malformed response yields a single error word; the output register sets the pace out.
// Input stalls only when both slots are full; a slot frees as its last word is loaded out.
// Synchronous reset clears the parser state, the slot flags and the output valid flag.
module der_ecdsa_signature_to_raw (
  input  logic         clk,
  input  logic         rst_n,
  dersig_in_if.sink    in_bus,
  dersig_out_if.source out_bus
);

  dersig_pkg::byte_wr_t wr;
  dersig_pkg::push_t    push;
  dersig_pkg::rd_req_t  rd;
  dersig_pkg::head_t    head;
  logic                 q_free;

  dersig_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_free (q_free),
    .wr     (wr),
    .push   (push)
  );

  dersig_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .push   (push),
    .rd     (rd),
    .q_free (q_free),
    .head   (head)
  );

  dersig_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .rd      (rd),
    .out_bus (out_bus)
  );

endmodule
